// File: sv/wpsp_pkg.sv
// shared types and constants for the wav pcm16 stream parser
// no dependencies

package wpsp_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NO_RIFF  = 3'd2,
        ST_NOT_PCM  = 3'd3,
        ST_NOT_16   = 3'd4,
        ST_NO_DATA  = 3'd5,
        ST_TRUNC    = 3'd6
    } t_status;

    localparam logic [31:0] RIFF_TAG     = 32'h4646_4952;  // "RIFF", byte 0 in low bits
    localparam logic [31:0] DATA_TAG     = 32'h6174_6164;  // "data", byte 0 in low bits
    localparam int          MIN_LEN      = 44;
    localparam logic [30:0] DEFAULT_RATE = 31'd48000;
    localparam logic [15:0] NEED_DEPTH   = 16'd16;
    localparam logic [15:0] NEED_FORMAT  = 16'd1;
    localparam logic [15:0] DEFAULT_CHAN = 16'd1;
    localparam logic [31:0] FIRST_CHUNK  = 32'd12;

    localparam int QDEPTH   = 4;
    localparam int QA_BITS  = $clog2(QDEPTH);
    localparam int QC_BITS  = $clog2(QDEPTH + 1);

    // work handed from the parser to the output side for one byte
    typedef struct packed {
        logic               has_smp;
        logic signed [15:0] smp;
        logic               has_st;
        t_status            st;
        logic [30:0]        rate;
        logic [15:0]        chan;
    } t_op;

endpackage

// File: sv/wav_pcm16_stream_parser_unit.sv
// top level of the wav pcm16 stream parser
// depends on wpsp_pkg, wpsp_front, wpsp_queue, wpsp_back

// Parses a RIFF/WAVE file fed one byte per beat, with i_is_final on the last
// byte, and returns each 16-bit little-endian sample of the data chunk as soon
// as its second byte arrives (kind 0), then one status beat (kind 1, last 1)
// carrying the check result, sample rate and channel count after the final
// byte; samples are provisional until that status says ok. A byte is taken
// every clock while the four-entry work queue has room, and the output
// register delivers one result per clock while pop is held, so the sustained
// rate is one byte per cycle; a final byte that also completes a sample
// yields two results from one queue entry. Each result passes through the
// work queue and then the output register. The byte position counter
// is POS_BITS wide and holds at its maximum, after which bytes are ignored
// except for their final flag.

module wav_pcm16_stream_parser_unit import wpsp_pkg::*; #(
    parameter int POS_BITS = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_in_byte,
    input  logic               i_is_final,
    output logic               empty,
    input  logic               pop,
    output logic               o_kind,
    output logic signed [15:0] o_sample,
    output logic [2:0]         o_status,
    output logic [30:0]        o_rate_hz,
    output logic [15:0]        o_chan_count,
    output logic               o_last
);

    logic front_push;
    t_op  front_op;
    t_op  q_head;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign full = q_full;

    wpsp_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push & ~q_full),
        .i_byte  (i_in_byte),
        .i_fin   (i_is_final),
        .o_push  (front_push),
        .o_op    (front_op)
    );

    wpsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_push),
        .i_wr_op (front_op),
        .i_rd    (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wpsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_sample     (o_sample),
        .o_status     (o_status),
        .o_rate_hz    (o_rate_hz),
        .o_chan_count (o_chan_count),
        .o_last       (o_last)
    );

endmodule

// File: sv/wpsp_front.sv
// byte parser: header fields, chunk walk and sample assembly
// depends on wpsp_pkg

module wpsp_front import wpsp_pkg::*; #(
    parameter int POS_BITS = 33
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output logic       o_push,
    output t_op        o_op
);

    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_riff, n_riff;
    logic [15:0]         r_fmt, n_fmt;
    logic [15:0]         r_depth, n_depth;
    logic [15:0]         r_chan, n_chan;
    logic [31:0]         r_rate, n_rate;
    logic [31:0]         r_gap, n_gap;      // bytes left before the next chunk header
    logic [2:0]          r_k, n_k;          // byte index inside the chunk header
    logic [31:0]         r_tag, n_tag;
    logic [31:0]         r_len, n_len;
    logic                r_found, n_found;
    logic [31:0]         r_rem, n_rem;      // data bytes still expected
    logic                r_par, n_par;
    logic [7:0]          r_low, n_low;

    logic [31:0] len_full;
    logic        riff_m;
    t_status     st;

    assign len_full = {i_byte, r_len[23:0]};
    assign riff_m   = (i_byte == RIFF_TAG[8*r_pos[1:0] +: 8]);

    always_comb begin
        n_pos   = r_pos;
        n_riff  = r_riff;
        n_fmt   = r_fmt;
        n_depth = r_depth;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_gap   = r_gap;
        n_k     = r_k;
        n_tag   = r_tag;
        n_len   = r_len;
        n_found = r_found;
        n_rem   = r_rem;
        n_par   = r_par;
        n_low   = r_low;
        o_push  = 1'b0;
        o_op    = '0;
        st      = ST_OK;

        if (i_valid) begin
            // counter saturated: byte dropped, only its final flag acts
            if (r_pos != '1) begin
                if (r_pos < POS_BITS'(36)) begin
                    case (r_pos[5:0])
                        6'd0:    n_riff = riff_m;
                        6'd1, 6'd2, 6'd3: n_riff = r_riff & riff_m;
                        6'd20:   n_fmt[7:0]    = i_byte;
                        6'd21:   n_fmt[15:8]   = i_byte;
                        6'd22:   n_chan[7:0]   = i_byte;
                        6'd23:   n_chan[15:8]  = i_byte;
                        6'd24:   n_rate[7:0]   = i_byte;
                        6'd25:   n_rate[15:8]  = i_byte;
                        6'd26:   n_rate[23:16] = i_byte;
                        6'd27:   n_rate[31:24] = i_byte;
                        6'd34:   n_depth[7:0]  = i_byte;
                        6'd35:   n_depth[15:8] = i_byte;
                        default: ;
                    endcase
                end

                if (!r_found) begin
                    if (r_gap != 32'd0) begin
                        n_gap = r_gap - 32'd1;
                    end else begin
                        n_k = r_k + 3'd1;
                        case (r_k)
                            3'd0: n_tag = {24'd0, i_byte};
                            3'd1: n_tag[15:8]  = i_byte;
                            3'd2: n_tag[23:16] = i_byte;
                            3'd3: n_tag[31:24] = i_byte;
                            3'd4: n_len = {24'd0, i_byte};
                            3'd5: n_len[15:8]  = i_byte;
                            3'd6: n_len[23:16] = i_byte;
                            3'd7: begin
                                n_len = len_full;
                                if (r_tag == DATA_TAG) begin
                                    // a data header closed by the final byte does not count
                                    if (!i_fin) begin
                                        n_found = 1'b1;
                                        n_rem   = len_full;
                                        n_par   = 1'b0;
                                    end
                                end else begin
                                    n_gap = len_full;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (r_rem != 32'd0) begin
                    if (r_par) begin
                        o_push      = 1'b1;
                        o_op.has_smp = 1'b1;
                        o_op.smp    = {i_byte, r_low};
                    end else begin
                        n_low = i_byte;
                    end
                    n_par = ~r_par;
                    n_rem = r_rem - 32'd1;
                end

                n_pos = r_pos + POS_BITS'(1);
            end

            if (i_fin) begin
                if (n_pos < POS_BITS'(MIN_LEN)) begin
                    st = ST_SHORT;
                end else if (!n_riff) begin
                    st = ST_NO_RIFF;
                end else if (n_fmt != NEED_FORMAT) begin
                    st = ST_NOT_PCM;
                end else if (n_depth != NEED_DEPTH) begin
                    st = ST_NOT_16;
                end else if (!n_found || n_len == 32'd0) begin
                    st = ST_NO_DATA;
                end else if (n_rem != 32'd0) begin
                    st = ST_TRUNC;
                end else begin
                    st = ST_OK;
                end
                o_push      = 1'b1;
                o_op.has_st = 1'b1;
                o_op.st     = st;
                o_op.rate   = (n_rate == 32'd0 || n_rate[31]) ? DEFAULT_RATE : n_rate[30:0];
                o_op.chan   = (n_chan == 16'd0) ? DEFAULT_CHAN : n_chan;

                // back to the reset state for the next file
                n_pos   = '0;
                n_riff  = 1'b0;
                n_fmt   = '0;
                n_depth = '0;
                n_chan  = '0;
                n_rate  = '0;
                n_gap   = FIRST_CHUNK;
                n_k     = '0;
                n_tag   = '0;
                n_len   = '0;
                n_found = 1'b0;
                n_rem   = '0;
                n_par   = 1'b0;
                n_low   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_riff  <= 1'b0;
            r_fmt   <= '0;
            r_depth <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_gap   <= FIRST_CHUNK;
            r_k     <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_found <= 1'b0;
            r_rem   <= '0;
            r_par   <= 1'b0;
            r_low   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_riff  <= n_riff;
            r_fmt   <= n_fmt;
            r_depth <= n_depth;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_gap   <= n_gap;
            r_k     <= n_k;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_found <= n_found;
            r_rem   <= n_rem;
            r_par   <= n_par;
            r_low   <= n_low;
        end
    end

endmodule

// File: sv/wpsp_queue.sv
// short queue of parser work between the front and the output side
// depends on wpsp_pkg

module wpsp_queue import wpsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wr_op,
    input  logic i_rd,
    output t_op  o_head,
    output logic o_empty,
    output logic o_full
);

    t_op                r_mem [QDEPTH];
    logic [QA_BITS-1:0] r_wp;
    logic [QA_BITS-1:0] r_rp;
    logic [QC_BITS-1:0] r_cnt;

    logic wr_en;
    logic rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QC_BITS'(QDEPTH));
    assign o_head  = r_mem[r_rp];
    assign wr_en   = i_wr & ~o_full;
    assign rd_en   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + QA_BITS'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + QA_BITS'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + QC_BITS'(1);
                2'b01:   r_cnt <= r_cnt - QC_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/wpsp_back.sv
// output side: turns queued work into result beats in an output register
// depends on wpsp_pkg

module wpsp_back import wpsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_head,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_kind,
    output logic signed [15:0] o_sample,
    output logic [2:0]         o_status,
    output logic [30:0]        o_rate_hz,
    output logic [15:0]        o_chan_count,
    output logic               o_last
);

    logic               r_valid;
    logic               r_half;     // sample of the head entry already sent
    logic               r_kind;
    logic signed [15:0] r_sample;
    logic [2:0]         r_status;
    logic [30:0]        r_rate;
    logic [15:0]        r_chan;

    logic load;
    logic take_smp;

    assign load     = (~r_valid | i_pop) & ~i_q_empty;
    assign take_smp = i_head.has_smp & ~r_half;
    // entry leaves the queue once its last beat is loaded
    assign o_q_pop  = load & ~(take_smp & i_head.has_st);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= take_smp & i_head.has_st;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (take_smp) begin
                r_kind   <= 1'b0;
                r_sample <= i_head.smp;
                r_status <= ST_OK;
                r_rate   <= '0;
                r_chan   <= '0;
            end else begin
                r_kind   <= 1'b1;
                r_sample <= '0;
                r_status <= i_head.st;
                r_rate   <= i_head.rate;
                r_chan   <= i_head.chan;
            end
        end
    end

    assign o_empty      = ~r_valid;
    assign o_kind       = r_kind;
    assign o_sample     = r_sample;
    assign o_status     = r_status;
    assign o_rate_hz    = r_rate;
    assign o_chan_count = r_chan;
    assign o_last       = r_kind;

endmodule
